// File: design/kmp_pkg.sv
// kmp_pkg: shared types and codes for the streaming KMP matcher.
// No dependencies; imported by kmp_out_stage, kmp_stream_matcher and the bench.
`default_nettype none

package kmp_pkg;

    // Default sizing for the top level parameters
    localparam int PATTERN_MAX_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;

    // Action codes of an input word
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    // Status codes of a result word
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DROP  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_start;
        logic [1:0]  status;
    } out_item_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: design/kmp_ram.sv
// kmp_ram: single write port, single read port synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/kmp_out_stage.sv
// kmp_out_stage: output register of the matcher's result channel.
// Depends on kmp_pkg for the result word type.
`default_nettype none

module kmp_out_stage
    import kmp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t load_data,
    output logic           free,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_item_t      result
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    // Slot can take a word when empty or when its word leaves this cycle
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until replaced
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire

// File: design/kmp_stream_matcher.sv
// kmp_stream_matcher: streaming Knuth-Morris-Pratt matcher, top level.
// Depends on kmp_pkg, kmp_ram (pattern and failure stores), kmp_out_stage.
`default_nettype none

// Channel   Signals                          Word
// input     item_valid, item_ready, item     action, data_byte, first
// output    result_valid, result_ready, ...  found, match_start, status
//
// A pattern or text word that walks the failure table goes from ST_IDLE to
// ST_STEP and stays there for each fallback step; the loop is one read of
// both stores a cycle. A dropped pattern word, a first pattern word or a text
// word with an empty pattern ends in ST_IDLE. One word is in work at a time.
// Reset clears lengths, position and the sequencer; the stores are not cleared.
// A result that finds the output register busy is parked until it drains.

module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_item_t      result
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_W = POSITION_BITS;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [LEN_W-1:0] border_reg, border_next;
    logic [LEN_W-1:0] matched_reg, matched_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       byte_reg, byte_next;
    logic             action_reg, action_next;
    out_item_t        hold_reg, hold_next;

    logic accept;
    logic slot_free;
    logic out_load;
    out_item_t out_data;
    out_item_t res_now;

    // Accept-cycle view of the state after any clear by first
    logic [LEN_W-1:0] eff_plen, eff_border, eff_matched, k_start;
    logic [POS_W-1:0] eff_pos;
    logic             full, quick;

    // Loop step signals
    logic [7:0]       pat_rdata;
    logic [LEN_W-1:0] fail_rdata;
    logic             hit, step_done, finish, text_found;
    logic [LEN_W-1:0] k_fin, k_sel;
    logic [POS_W-1:0] start_full;

    // Store write port
    logic             wr_en;
    logic [LEN_W-1:0] wr_idx;
    logic [7:0]       wr_byte;
    logic [LEN_W-1:0] wr_fail;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Apply the clear requested by first
    always_comb
    begin
        eff_plen    = plen_reg;
        eff_border  = border_reg;
        eff_matched = item.first ? '0 : matched_reg;
        eff_pos     = pos_reg;
        if (item.first && item.action == ACT_PATTERN)
        begin
            eff_plen   = '0;
            eff_border = '0;
        end
        if (item.first && item.action == ACT_TEXT)
        begin
            eff_pos = '0;
        end
        full = (eff_plen >= LEN_W'(PATTERN_MAX));
        if (item.action == ACT_PATTERN)
        begin
            k_start = eff_border;
            quick   = full || (eff_plen == '0);
        end
        else
        begin
            k_start = (eff_matched >= eff_plen) ? '0 : eff_matched;
            quick   = (eff_plen == '0);
        end
    end

    // Compare the stored byte against the word in work
    assign hit        = (pat_rdata == byte_reg);
    assign step_done  = hit || (k_reg == '0);
    assign k_fin      = hit ? (k_reg + LEN_W'(1)) : '0;
    assign text_found = (k_fin == plen_reg);
    assign start_full = pos_reg - POS_W'(plen_reg) + POS_W'(1);

    assign finish = (accept && quick) || (state_reg == ST_STEP && step_done);

    // Read address: start of the walk, or the fallback border
    assign k_sel = (state_reg == ST_IDLE) ? k_start : fail_rdata;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!quick)
                    begin
                        state_next = ST_STEP;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_STEP:
            begin
                if (step_done)
                begin
                    state_next = slot_free ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word of the item that finishes this cycle
    always_comb
    begin
        res_now = '{found: 1'b0, match_start: 32'd0, status: STATUS_OK};
        if (state_reg == ST_IDLE)
        begin
            if (item.action == ACT_PATTERN)
            begin
                res_now.status = full ? STATUS_DROP : STATUS_OK;
            end
            else
            begin
                res_now.status = STATUS_EMPTY;
            end
        end
        else if (action_reg == ACT_TEXT && text_found)
        begin
            res_now.found       = 1'b1;
            res_now.match_start = 32'(start_full);
        end
    end

    // Output register loading and parking
    always_comb
    begin
        out_load  = 1'b0;
        out_data  = res_now;
        hold_next = hold_reg;
        unique case (state_reg)
            ST_EMIT:
            begin
                out_load = slot_free;
                out_data = hold_reg;
            end
            ST_IDLE, ST_STEP:
            begin
                if (finish)
                begin
                    out_load = slot_free;
                    if (!slot_free)
                    begin
                        hold_next = res_now;
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Matcher state updates and store writes
    always_comb
    begin
        plen_next    = plen_reg;
        border_next  = border_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        byte_next    = byte_reg;
        action_next  = action_reg;
        wr_en        = 1'b0;
        wr_idx       = plen_reg;
        wr_byte      = byte_reg;
        wr_fail      = k_fin;
        if (accept)
        begin
            plen_next    = eff_plen;
            border_next  = eff_border;
            matched_next = eff_matched;
            pos_next     = eff_pos;
            k_next       = k_start;
            byte_next    = item.data_byte;
            action_next  = item.action;
            if (item.action == ACT_PATTERN && !full && eff_plen == '0)
            begin
                // First pattern byte: no border to walk
                wr_en       = 1'b1;
                wr_idx      = '0;
                wr_byte     = item.data_byte;
                wr_fail     = '0;
                plen_next   = LEN_W'(1);
                border_next = '0;
            end
            else if (item.action == ACT_TEXT && eff_plen == '0)
            begin
                matched_next = '0;
                pos_next     = eff_pos + POS_W'(1);
            end
        end
        else if (state_reg == ST_STEP)
        begin
            if (!step_done)
            begin
                // Fall back through the failure table
                k_next = fail_rdata;
            end
            else if (action_reg == ACT_PATTERN)
            begin
                wr_en       = 1'b1;
                border_next = k_fin;
                plen_next   = plen_reg + LEN_W'(1);
            end
            else
            begin
                // Continue with the overlap after a full match
                matched_next = text_found ? border_reg : k_fin;
                pos_next     = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            plen_reg    <= '0;
            border_reg  <= '0;
            matched_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            border_reg  <= border_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        byte_reg   <= byte_next;
        action_reg <= action_next;
        hold_reg   <= hold_next;
    end

    // Pattern bytes
    kmp_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX),
        .ADDR_W(IDX_W)
    ) u_pattern_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(IDX_W'(wr_idx)),
        .wdata(wr_byte),
        .raddr(IDX_W'(k_sel)),
        .rdata(pat_rdata)
    );

    // Border length of each pattern prefix
    kmp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (PATTERN_MAX),
        .ADDR_W(IDX_W)
    ) u_failure_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(IDX_W'(wr_idx)),
        .wdata(wr_fail),
        .raddr(IDX_W'(k_sel - LEN_W'(1))),
        .rdata(fail_rdata)
    );

    kmp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .load_data   (out_data),
        .free        (slot_free),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Walk index stays inside the stored pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> k_reg < plen_reg)
        else $error("walk index past pattern end");

    // Matched length is a proper prefix or empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (matched_reg < plen_reg) || (matched_reg == '0))
        else $error("matched length not a proper prefix");

    // Border is a proper prefix or empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (border_reg < plen_reg) || (border_reg == '0))
        else $error("border length not a proper prefix");

    // Pattern length never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length past capacity");

    // A parked result drains as soon as the output is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && result_ready) |=> state_reg == ST_IDLE)
        else $error("parked result not drained");

endmodule

`default_nettype wire

// File: sim/kmp_stream_matcher_tb.sv
// kmp_stream_matcher_tb: self-checking bench for the streaming KMP matcher.
// Depends on kmp_pkg and kmp_stream_matcher; a directed plan, then random
// pattern/text sequences, scored by an in-bench matcher predictor or typed rows.
`timescale 1ns / 100ps

module kmp_stream_matcher_tb;
    import kmp_pkg::*;

    localparam int PAT_CAP      = PATTERN_MAX_DEF;
    localparam int RANDOM_WORDS = 540;
    // The limit covers several times over the slowest word walking the whole table,
    // the longest sender gap, a receiver stall segment and the single hold-off.
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int PLAN_ROWS    = 26;

    typedef struct {
        in_item_t  w;
        int        reps;
        bit        typed;
        out_item_t exp;
    } plan_row_t;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    // Predictor state
    logic [7:0]  pat_bytes  [PAT_CAP];
    logic [6:0]  border_tab [PAT_CAP];
    logic [6:0]  pat_len;
    logic [6:0]  brd_len;
    logic [6:0]  hit_len;
    logic [31:0] text_pos;

    out_item_t outcome_q [$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    bit        hold_off_req = 1'b0;

    kmp_stream_matcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_item_t pw(logic [7:0] b, logic f);
        in_item_t w;
        w.action    = ACT_PATTERN;
        w.data_byte = b;
        w.first     = f;
        return w;
    endfunction

    function automatic in_item_t tw(logic [7:0] b, logic f);
        in_item_t w;
        w.action    = ACT_TEXT;
        w.data_byte = b;
        w.first     = f;
        return w;
    endfunction

    function automatic out_item_t res(logic f, logic [31:0] s, logic [1:0] st);
        out_item_t o;
        o.found       = f;
        o.match_start = s;
        o.status      = st;
        return o;
    endfunction

    // Longest pattern prefix ending at byte b, given k bytes already matched
    function automatic logic [6:0] extend_prefix(logic [6:0] k, logic [7:0] b);
        while (k != 0 && pat_bytes[k] != b)
            k = border_tab[k - 1];
        if (pat_bytes[k] == b)
            k = k + 7'd1;
        return k;
    endfunction

    // Apply one word to the predictor state and return the result it yields
    function automatic out_item_t next_outcome(in_item_t w);
        out_item_t   o;
        logic [6:0]  k;
        o = res(1'b0, 32'd0, STATUS_OK);
        if (w.action == ACT_PATTERN)
        begin
            if (w.first)
            begin
                pat_len = '0;
                brd_len = '0;
                hit_len = '0;
            end
            if (pat_len >= PAT_CAP)
                o.status = STATUS_DROP;
            else
            begin
                pat_bytes[pat_len] = w.data_byte;
                if (pat_len == 0)
                    brd_len = '0;
                else
                    brd_len = extend_prefix(brd_len, w.data_byte);
                border_tab[pat_len] = brd_len;
                pat_len = pat_len + 7'd1;
            end
        end
        else
        begin
            if (w.first)
            begin
                hit_len  = '0;
                text_pos = '0;
            end
            if (pat_len == 0)
            begin
                o.status = STATUS_EMPTY;
                hit_len  = '0;
            end
            else
            begin
                k = (hit_len >= pat_len) ? 7'd0 : hit_len;
                k = extend_prefix(k, w.data_byte);
                if (k == pat_len)
                begin
                    o.found       = 1'b1;
                    o.match_start = text_pos - 32'(pat_len) + 32'd1;
                    k             = border_tab[pat_len - 1];
                end
                hit_len = k;
            end
            text_pos = text_pos + 32'd1;
        end
        return o;
    endfunction

    // Offer one word in a burst/gap rhythm, then log its expected result
    task automatic drive(in_item_t w, bit typed, out_item_t typed_exp);
        int        gap;
        out_item_t pred;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left = burst_left - 1;
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        pred = next_outcome(w);
        outcome_q.push_back(typed ? typed_exp : pred);
    endtask

    // Random sequences: a pattern over a small alphabet, then text drawn
    // mostly from that alphabet so matches and fallbacks are frequent
    task automatic run_random(int target);
        int          sent;
        int          nsym;
        int          plen;
        int          tlen;
        int          r;
        bit          restart;
        logic [7:0]  alpha [4];
        sent = 0;
        while (sent < target)
        begin
            foreach (alpha[i])
                alpha[i] = 8'($urandom);
            nsym = $urandom_range(1, 4);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(56, 70)
                                                 : $urandom_range(1, 6);
            for (int j = 0; j < plen; j++)
            begin
                drive(pw(alpha[$urandom_range(0, nsym - 1)], j == 0), 1'b0, '0);
                sent++;
            end
            tlen    = $urandom_range(8, 40);
            restart = 1'($urandom);
            for (int j = 0; j < tlen; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    drive(pw(alpha[$urandom_range(0, nsym - 1)], 1'b0), 1'b0, '0);
                else if (r < 8)
                    drive(tw(8'($urandom), 1'($urandom)), 1'b0, '0);
                else
                    drive(tw(alpha[$urandom_range(0, nsym - 1)],
                             (j == 0 && restart) || r < 10), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        plan_row_t plan [PLAN_ROWS];
        plan = '{
            // text before any pattern, then with a restart
            '{tw(8'h00, 1'b0), 1, 1'b1, res(1'b0, 32'd0, STATUS_EMPTY)},
            '{tw(8'hFF, 1'b1), 1, 1'b1, res(1'b0, 32'd0, STATUS_EMPTY)},
            // pattern "aba", then overlapping matches in "ababa"
            '{pw(8'h61, 1'b1), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{pw(8'h62, 1'b0), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{pw(8'h61, 1'b0), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{tw(8'h61, 1'b1), 1, 1'b0, '0},
            '{tw(8'h62, 1'b0), 1, 1'b0, '0},
            '{tw(8'h61, 1'b0), 1, 1'b0, '0},
            '{tw(8'h62, 1'b0), 1, 1'b0, '0},
            '{tw(8'h61, 1'b0), 1, 1'b0, '0},
            // clear the pattern mid-scan; text position carries on
            '{pw(8'h61, 1'b1), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{pw(8'h62, 1'b0), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{tw(8'h61, 1'b0), 1, 1'b0, '0},
            // grow the pattern while a partial match is open
            '{pw(8'h63, 1'b0), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{tw(8'h62, 1'b0), 1, 1'b0, '0},
            '{tw(8'h63, 1'b0), 1, 1'b0, '0},
            // fill the pattern to capacity, then overflow it
            '{pw(8'hFF, 1'b1), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{pw(8'hFF, 1'b0), PAT_CAP - 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{pw(8'hFF, 1'b0), 2, 1'b1, res(1'b0, 32'd0, STATUS_DROP)},
            // full-length matches back to back, then a long fallback
            '{tw(8'hFF, 1'b1), 1, 1'b0, '0},
            '{tw(8'hFF, 1'b0), 69, 1'b0, '0},
            '{tw(8'hFE, 1'b0), 1, 1'b0, '0},
            // a first word on a full pattern is never dropped
            '{pw(8'h00, 1'b1), 1, 1'b1, res(1'b0, 32'd0, STATUS_OK)},
            '{tw(8'h00, 1'b0), 1, 1'b0, '0},
            '{tw(8'h80, 1'b0), 1, 1'b0, '0},
            '{tw(8'h00, 1'b1), 1, 1'b0, '0}
        };

        pat_len  = '0;
        brd_len  = '0;
        hit_len  = '0;
        text_pos = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
            for (int n = 0; n < plan[r].reps; n++)
                drive(plan[r].w, plan[r].typed, plan[r].exp);

        hold_off_req = 1'b1;
        run_random(RANDOM_WORDS);
        item_valid <= 1'b0;

        // Drain, then watch for stray results
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: segments of always-ready, random and sparse ready, plus one
    // long hold-off so the block backs up and stalls its input
    initial
    begin
        int seg_len;
        int mode;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            seg_len = $urandom_range(20, 80);
            mode    = $urandom_range(0, 2);
            repeat (seg_len)
            begin
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom);
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Score each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && result_valid && result_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d start=%0d status=%0d",
                             result.found, result.match_start, result.status);
            end
            else
            begin
                exp = outcome_q.pop_front();
                if (result.found != exp.found || result.match_start != exp.match_start
                    || result.status != exp.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: found %0d/%0d start %0d/%0d status %0d/%0d",
                                 exp.found, result.found, exp.match_start,
                                 result.match_start, exp.status, result.status);
                end
            end
        end
    end

    // Count cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
